// ===== rtl/efrgc_pkg.sv =====
package efrgc_pkg;

    // default table size
    localparam int NUM_STATES_DEF = 8;

    // results returned per request at most
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // request codes
    localparam logic [2:0] REQ_STEP    = 3'd0;
    localparam logic [2:0] REQ_CHANGE  = 3'd1;
    localparam logic [2:0] REQ_DUMP    = 3'd2;
    localparam logic [2:0] REQ_LIST    = 3'd3;
    localparam logic [2:0] REQ_DEL_ONE = 3'd4;
    localparam logic [2:0] REQ_DEL_ALL = 3'd5;

    // result kinds
    localparam logic [2:0] KIND_NEW_STATE     = 3'd0;
    localparam logic [2:0] KIND_ROW           = 3'd1;
    localparam logic [2:0] KIND_GARBAGE       = 3'd2;
    localparam logic [2:0] KIND_NO_GARBAGE    = 3'd3;
    localparam logic [2:0] KIND_DELETED       = 3'd4;
    localparam logic [2:0] KIND_NOT_DELETED   = 3'd5;
    localparam logic [2:0] KIND_DEL_ENTRY     = 3'd6;
    localparam logic [2:0] KIND_NONE_DELETED  = 3'd7;

    // power-up links of the first eight states, repeated for larger tables
    localparam int RST_ZERO [8] = '{3, 2, 4, 6, 7, 1, 5, 0};
    localparam int RST_ONE  [8] = '{1, 7, 5, 3, 3, 0, 2, 4};

    // one result item
    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] entry;
        logic [2:0] next_zero;
        logic [2:0] next_one;
    } result_t;

endpackage

// ===== rtl/editable_fsm_reachability_gc.sv =====
// Editable state machine with reachability garbage collection. Requests arrive on the s_ stream
// (tuser = request code) and results leave on the m_ stream, tlast marking the final result of
// a request; one request is worked on at a time and s_tready is high only while the block waits
// for a request. The two link tables sit in synchronous memories with one read port each, so
// the read port sets the pace: a step reads the link of the current state, emits the new state
// and hands it over, a change link is done in the accept cycle, and a dump reads and then emits
// each state in turn. List garbage and the two deletes first run a reachability walk of up to
// NUM_STATES passes over all states until a pass adds nothing; then list garbage and delete all
// scan the deleted and reachable marks at one state per cycle, while delete one checks only its
// target. Results wait in a one-deep hold stage before the output register, so tlast is known
// when a result is released; a stalled output stalls the scan. After reset the tables read
// their power-up links through per-entry valid bits, so no clearing pass is needed.
module editable_fsm_reachability_gc #(
    parameter int NUM_STATES = efrgc_pkg::NUM_STATES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] input_bit, [3:1] target, [7:4] zero
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [2:0] entry, [5:3] next_zero, [8:6] next_one, [15:9] zero
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast    // last
);
    import efrgc_pkg::*;

    localparam int SW = $clog2(NUM_STATES);
    localparam logic [SW-1:0] LAST_IDX = SW'(NUM_STATES - 1);

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b00_0000_0001,
        ST_STEP_RD = 10'b00_0000_0010,
        ST_STEP_EM = 10'b00_0000_0100,
        ST_DUMP_RD = 10'b00_0000_1000,
        ST_DUMP_EM = 10'b00_0001_0000,
        ST_WALK    = 10'b00_0010_0000,
        ST_LIST    = 10'b00_0100_0000,
        ST_TAIL    = 10'b00_1000_0000,
        ST_DEL1    = 10'b01_0000_0000,
        ST_FLUSH   = 10'b10_0000_0000
    } state_t;

    // control registers
    state_t                  state_reg, state_next;
    logic [SW-1:0]           cur_reg, cur_next;
    logic [NUM_STATES-1:0]   del_reg, del_next;
    logic                    issue_reg, issue_next;
    logic                    ev_vld_reg, ev_vld_next;
    logic                    hold_vld_reg, hold_vld_next;
    logic                    out_vld_reg, out_vld_next;
    logic [NUM_STATES-1:0]   vld_zero_reg, vld_one_reg;

    // payload registers
    logic [SW-1:0]           idx_reg, idx_next;
    logic                    changed_reg, changed_next;
    logic [NUM_STATES-1:0]   reach_reg, reach_next;
    logic [2:0]              req_reg, req_next;
    logic                    bit_reg, bit_next;
    logic [2:0]              tgt_reg, tgt_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    result_t                 hold_reg, hold_next;
    result_t                 out_reg, out_next;
    logic                    out_last_reg, out_last_next;

    // link memories and their read side
    logic [SW-1:0]           link_zero_mem [NUM_STATES];
    logic [SW-1:0]           link_one_mem  [NUM_STATES];
    logic [SW-1:0]           rst_zero [NUM_STATES];
    logic [SW-1:0]           rst_one  [NUM_STATES];
    logic [SW-1:0]           rd_mem_zero_reg, rd_mem_one_reg;
    logic [SW-1:0]           rd_rst_zero_reg, rd_rst_one_reg;
    logic                    rd_vld_zero_reg, rd_vld_one_reg;
    logic [SW-1:0]           rd_idx_reg;
    logic [SW-1:0]           rd_zero, rd_one;

    logic                    wr_zero_en, wr_one_en;
    logic [SW-1:0]           wr_data;

    logic                    in_xfer, out_free, can_emit, cap_hit, emit_ok;
    logic                    emit_req, emit_take;
    result_t                 emit_res;
    logic                    tgt_in_ok, tgt_ok;
    logic [SW-1:0]           tgt_idx;

    // power-up link tables
    for (genvar g = 0; g < NUM_STATES; g++) begin : g_rst
        assign rst_zero[g] = SW'(RST_ZERO[g % 8] % NUM_STATES);
        assign rst_one[g]  = SW'(RST_ONE[g % 8] % NUM_STATES);
    end

    // memories: write on change link, read at the scan index every cycle
    always_ff @(posedge aclk) begin
        if (wr_zero_en) begin
            link_zero_mem[cur_reg] <= wr_data;
        end
        if (wr_one_en) begin
            link_one_mem[cur_reg] <= wr_data;
        end
        rd_mem_zero_reg <= link_zero_mem[idx_reg];
        rd_mem_one_reg  <= link_one_mem[idx_reg];
        rd_rst_zero_reg <= rst_zero[idx_reg];
        rd_rst_one_reg  <= rst_one[idx_reg];
        rd_vld_zero_reg <= vld_zero_reg[idx_reg];
        rd_vld_one_reg  <= vld_one_reg[idx_reg];
        rd_idx_reg      <= idx_reg;
    end

    // entries never written read their power-up link
    assign rd_zero = rd_vld_zero_reg ? rd_mem_zero_reg : rd_rst_zero_reg;
    assign rd_one  = rd_vld_one_reg  ? rd_mem_one_reg  : rd_rst_one_reg;

    // handshake helpers
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !out_vld_reg || m_tready;
    assign can_emit  = !hold_vld_reg || out_free;
    assign cap_hit   = (cnt_reg == CNT_W'(MAX_RESULTS));
    assign emit_ok   = cap_hit || can_emit;

    assign tgt_in_ok = (int'(s_tdata[3:1]) < NUM_STATES);
    assign tgt_ok    = (int'(tgt_reg) < NUM_STATES);
    assign tgt_idx   = SW'(tgt_reg);

    // change link writes straight into the memory in the accept cycle
    assign wr_data    = SW'(s_tdata[3:1]);
    assign wr_zero_en = in_xfer && (s_tuser == REQ_CHANGE) && tgt_in_ok && !s_tdata[0];
    assign wr_one_en  = in_xfer && (s_tuser == REQ_CHANGE) && tgt_in_ok && s_tdata[0];

    // sequencer
    always_comb begin
        logic          grow;
        logic          cond;
        logic          ok;
        logic [SW-1:0] nxt;

        state_next    = state_reg;
        cur_next      = cur_reg;
        del_next      = del_reg;
        issue_next    = issue_reg;
        ev_vld_next   = ev_vld_reg;
        hold_vld_next = hold_vld_reg;
        idx_next      = idx_reg;
        changed_next  = changed_reg;
        reach_next    = reach_reg;
        req_next      = req_reg;
        bit_next      = bit_reg;
        tgt_next      = tgt_reg;
        cnt_next      = cnt_reg;
        hold_next     = hold_reg;
        out_next      = out_reg;
        out_last_next = out_last_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        emit_req      = 1'b0;
        emit_res      = '0;
        grow          = 1'b0;
        cond          = 1'b0;
        ok            = 1'b0;
        nxt           = '0;

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    req_next = s_tuser;
                    bit_next = s_tdata[0];
                    tgt_next = s_tdata[3:1];
                    cnt_next = '0;
                    case (s_tuser)
                        REQ_STEP: begin
                            idx_next   = cur_reg;
                            state_next = ST_STEP_RD;
                        end
                        REQ_DUMP: begin
                            idx_next   = '0;
                            state_next = ST_DUMP_RD;
                        end
                        REQ_LIST, REQ_DEL_ONE, REQ_DEL_ALL: begin
                            idx_next            = '0;
                            issue_next          = 1'b1;
                            ev_vld_next         = 1'b0;
                            changed_next        = 1'b0;
                            reach_next          = '0;
                            reach_next[cur_reg] = 1'b1;
                            state_next          = ST_WALK;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_STEP_RD: begin
                state_next = ST_STEP_EM;
            end

            // follow one link of the current state
            ST_STEP_EM: begin
                nxt            = bit_reg ? rd_one : rd_zero;
                emit_req       = 1'b1;
                emit_res.kind  = KIND_NEW_STATE;
                emit_res.entry = 3'(nxt);
                if (emit_ok) begin
                    cur_next   = nxt;
                    state_next = ST_FLUSH;
                end
            end

            ST_DUMP_RD: begin
                state_next = ST_DUMP_EM;
            end

            // one live row per read
            ST_DUMP_EM: begin
                if (!del_reg[idx_reg]) begin
                    emit_req           = 1'b1;
                    emit_res.kind      = KIND_ROW;
                    emit_res.entry     = 3'(idx_reg);
                    emit_res.next_zero = 3'(rd_zero);
                    emit_res.next_one  = 3'(rd_one);
                end
                if (!emit_req || emit_ok) begin
                    if (idx_reg == LAST_IDX) begin
                        state_next = ST_FLUSH;
                    end else begin
                        idx_next   = idx_reg + SW'(1);
                        state_next = ST_DUMP_RD;
                    end
                end
            end

            // reachability passes: issue reads in order, expand each row in the cycle after its read
            ST_WALK: begin
                ev_vld_next = issue_reg;
                if (issue_reg) begin
                    if (idx_reg == LAST_IDX) begin
                        issue_next = 1'b0;
                    end else begin
                        idx_next = idx_reg + SW'(1);
                    end
                end
                if (ev_vld_reg) begin
                    if (reach_reg[rd_idx_reg] && !del_reg[rd_idx_reg]) begin
                        grow                = !reach_reg[rd_zero] || !reach_reg[rd_one];
                        reach_next[rd_zero] = 1'b1;
                        reach_next[rd_one]  = 1'b1;
                    end
                    if (rd_idx_reg == LAST_IDX) begin
                        if (changed_reg || grow) begin
                            idx_next     = '0;
                            issue_next   = 1'b1;
                            changed_next = 1'b0;
                        end else if (req_reg == REQ_DEL_ONE) begin
                            state_next = ST_DEL1;
                        end else begin
                            idx_next   = '0;
                            state_next = ST_LIST;
                        end
                    end else begin
                        changed_next = changed_reg || grow;
                    end
                end
            end

            // live and unreachable states, one per cycle unless a stalled output holds the scan
            ST_LIST: begin
                cond = !del_reg[idx_reg] && !reach_reg[idx_reg];
                if (cond) begin
                    emit_req       = 1'b1;
                    emit_res.kind  = (req_reg == REQ_DEL_ALL) ? KIND_DEL_ENTRY : KIND_GARBAGE;
                    emit_res.entry = 3'(idx_reg);
                end
                if (!cond || emit_ok) begin
                    if (cond && (req_reg == REQ_DEL_ALL)) begin
                        del_next[idx_reg] = 1'b1;
                    end
                    if (idx_reg == LAST_IDX) begin
                        state_next = ST_TAIL;
                    end else begin
                        idx_next = idx_reg + SW'(1);
                    end
                end
            end

            // nothing found
            ST_TAIL: begin
                if (cnt_reg == '0) begin
                    emit_req      = 1'b1;
                    emit_res.kind = (req_reg == REQ_DEL_ALL) ? KIND_NONE_DELETED
                                                             : KIND_NO_GARBAGE;
                    if (emit_ok) begin
                        state_next = ST_FLUSH;
                    end
                end else begin
                    state_next = ST_FLUSH;
                end
            end

            // delete one state if live and unreachable
            ST_DEL1: begin
                ok             = tgt_ok && !reach_reg[tgt_idx] && !del_reg[tgt_idx];
                emit_req       = 1'b1;
                emit_res.kind  = ok ? KIND_DELETED : KIND_NOT_DELETED;
                emit_res.entry = tgt_reg;
                if (emit_ok) begin
                    if (ok) begin
                        del_next[tgt_idx] = 1'b1;
                    end
                    state_next = ST_FLUSH;
                end
            end

            // release the held result as the final one
            ST_FLUSH: begin
                if (!hold_vld_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_next      = hold_reg;
                    out_last_next = 1'b1;
                    out_vld_next  = 1'b1;
                    hold_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // a new result pushes the held one to the output register
        emit_take = emit_req && !cap_hit && can_emit;
        if (emit_take) begin
            if (hold_vld_reg) begin
                out_next      = hold_reg;
                out_last_next = 1'b0;
                out_vld_next  = 1'b1;
            end
            hold_next     = emit_res;
            hold_vld_next = 1'b1;
            cnt_next      = cnt_reg + CNT_W'(1);
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cur_reg      <= SW'(1 % NUM_STATES);
            del_reg      <= '0;
            issue_reg    <= 1'b0;
            ev_vld_reg   <= 1'b0;
            hold_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            vld_zero_reg <= '0;
            vld_one_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            del_reg      <= del_next;
            issue_reg    <= issue_next;
            ev_vld_reg   <= ev_vld_next;
            hold_vld_reg <= hold_vld_next;
            out_vld_reg  <= out_vld_next;
            if (wr_zero_en) begin
                vld_zero_reg[cur_reg] <= 1'b1;
            end
            if (wr_one_en) begin
                vld_one_reg[cur_reg] <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        changed_reg  <= changed_next;
        reach_reg    <= reach_next;
        req_reg      <= req_next;
        bit_reg      <= bit_next;
        tgt_reg      <= tgt_next;
        cnt_reg      <= cnt_next;
        hold_reg     <= hold_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    // result port
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'b0, out_reg.next_one, out_reg.next_zero, out_reg.entry};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/efrgc_checker.sv =====
module efrgc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,   // [0] input_bit, [3:1] target, [7:4] zero
    input logic [2:0]  s_tuser,   // [2:0] req_type
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,   // [2:0] entry, [5:3] next_zero, [8:6] next_one, [15:9] zero
    input logic [2:0]  m_tuser,   // [2:0] kind
    input logic        m_tlast
);
    import efrgc_pkg::*;

    logic s_xfer;
    assign s_xfer = s_tvalid && s_tready && (s_tdata[7:4] == s_tdata[7:4]);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // a step keeps the block busy while the link is read
    a_step_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && (s_tuser == REQ_STEP) |=> !s_tready)
        else $error("step did not occupy the block");

    // a change link finishes in its accept cycle
    a_change_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && (s_tuser == REQ_CHANGE) |=> s_tready)
        else $error("change link left the block busy");

    // single-result kinds always close their request
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tuser == KIND_NEW_STATE) || (m_tuser == KIND_DELETED)
                     || (m_tuser == KIND_NOT_DELETED) || (m_tuser == KIND_NO_GARBAGE)
                     || (m_tuser == KIND_NONE_DELETED)) |-> m_tlast)
        else $error("single result without tlast");

    // link fields are zero outside table rows
    a_link_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != KIND_ROW) |-> (m_tdata[15:3] == 13'd0))
        else $error("link fields set outside a table row");

endmodule

bind editable_fsm_reachability_gc efrgc_checker u_efrgc_checker (.*);
